[design/dtinf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dtinf_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned FEAT_IDX_W = 4;
  localparam int unsigned NODE_IDX_W = 9;
  localparam int unsigned LIMIT_W = 4;
  localparam int unsigned FEAT_CMP_W = 7;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd8;

  typedef enum logic [1:0] {
    OP_WRITE_NODE = 2'd0,
    OP_LOAD_FEAT  = 2'd1,
    OP_PREDICT    = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_NODE,
    S_FEAT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic                  leaf;
    logic [FEAT_IDX_W-1:0] feat;
    logic [VALUE_W-1:0]    value;
  } node_t;

  localparam int unsigned NODE_W = $bits(node_t);

endpackage

`default_nettype wire

[design/dtinf_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module dtinf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[design/decision_tree_inference_unit.sv]
// Write-node and load-feature words are accepted back to back; the input does not stall after them.
// Predict: the walk goes down at most 8 levels (the smaller of depth_limit and MAX_LEVELS).
// Each level costs a node read then a row read; a step off the table ends the walk early.
// Input stalls while a walk is in progress and until its result moves to the output.
// Reset: rst_ni asynchronous active low, clears control and sets depth_limit to 8.
// Node and row memories are not cleared; entries are valid once written.
`timescale 1ns / 1ps
`default_nettype none

module decision_tree_inference_unit #(
  parameter int unsigned NODES      = 511,
  parameter int unsigned FEATURES   = 16,
  parameter int unsigned MAX_LEVELS = 8
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [dtinf_pkg::LIMIT_W-1:0]        cfg_wdata_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic [1:0]                           op_i,
  input  wire logic [dtinf_pkg::NODE_IDX_W-1:0]     node_index_i,
  input  wire logic                                 node_is_leaf_i,
  input  wire logic [dtinf_pkg::FEAT_IDX_W-1:0]     node_feature_i,
  input  wire logic signed [dtinf_pkg::VALUE_W-1:0] node_value_i,
  input  wire logic [dtinf_pkg::FEAT_IDX_W-1:0]     feature_index_i,
  input  wire logic signed [dtinf_pkg::VALUE_W-1:0] feature_value_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic signed [dtinf_pkg::VALUE_W-1:0]      prediction_o,
  output logic                                      status_o
);

  import dtinf_pkg::*;

  localparam int unsigned NAW = $clog2(NODES);
  localparam int unsigned FAW = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam int unsigned NW  = $clog2(NODES) + 2;
  localparam int unsigned CW  = (NW > NODE_IDX_W) ? NW : NODE_IDX_W;

  state_e state_q, state_d;

  logic [LIMIT_W-1:0] depth_limit_q;
  logic [LIMIT_W-1:0] limit;
  logic [LIMIT_W-1:0] level_q;
  logic [NW-1:0]      node_q;
  logic [NW-1:0]      child;
  logic [VALUE_W-1:0] res_pred_q;
  logic               res_stat_q;
  logic [VALUE_W-1:0] out_pred_q;
  logic               out_stat_q;
  logic               out_valid_q;

  logic               in_acc;
  logic               out_free;
  logic               node_end;
  logic               depth_out;
  logic               feat_bad;
  logic               go_right;
  logic               child_bad;

  logic               node_we;
  logic               node_re;
  logic [NAW-1:0]     node_raddr;
  logic [NODE_W-1:0]  node_wdata;
  logic [NODE_W-1:0]  node_rdata;
  node_t              nd;
  logic               feat_we;
  logic               feat_re;
  logic [VALUE_W-1:0] feat_rdata;

  assign nd        = node_t'(node_rdata);
  assign limit     = (depth_limit_q > LIMIT_W'(MAX_LEVELS)) ? LIMIT_W'(MAX_LEVELS)
                                                          : depth_limit_q;
  assign in_acc    = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign depth_out = level_q >= limit;
  assign feat_bad  = FEAT_CMP_W'(nd.feat) >= FEAT_CMP_W'(FEATURES);
  assign node_end  = nd.leaf || depth_out || feat_bad;
  assign go_right  = !($signed(feat_rdata) < $signed(nd.value));
  assign child     = (node_q << 1) + NW'(1) + NW'(go_right);
  assign child_bad = child >= NW'(NODES);

  assign node_wdata = {node_is_leaf_i, node_feature_i, node_value_i};

  dtinf_ram #(
    .WIDTH (NODE_W),
    .DEPTH (NODES),
    .AW    (NAW)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (NAW'(node_index_i)),
    .wdata_i (node_wdata),
    .re_i    (node_re),
    .raddr_i (node_raddr),
    .rdata_o (node_rdata)
  );

  dtinf_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (FEATURES),
    .AW    (FAW)
  ) u_feat_ram (
    .clk_i   (clk_i),
    .we_i    (feat_we),
    .waddr_i (FAW'(feature_index_i)),
    .wdata_i (feature_value_i),
    .re_i    (feat_re),
    .raddr_i (FAW'(nd.feat)),
    .rdata_o (feat_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && op_i == OP_PREDICT) begin
          state_d = S_NODE;
        end
      end
      S_NODE: begin
        state_d = node_end ? S_DONE : S_FEAT;
      end
      S_FEAT: begin
        state_d = child_bad ? S_DONE : S_NODE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    node_we    = 1'b0;
    node_re    = 1'b0;
    node_raddr = '0;
    feat_we    = 1'b0;
    feat_re    = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        node_we    = in_acc && op_i == OP_WRITE_NODE
                     && CW'(node_index_i) < CW'(NODES);
        feat_we    = in_acc && op_i == OP_LOAD_FEAT
                     && FEAT_CMP_W'(feature_index_i) < FEAT_CMP_W'(FEATURES);
        node_re    = in_acc && op_i == OP_PREDICT;
      end
      S_NODE: begin
        feat_re = !node_end;
      end
      S_FEAT: begin
        node_re    = !child_bad;
        node_raddr = NAW'(child);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      depth_limit_q <= LIMIT_RESET;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        depth_limit_q <= cfg_wdata_i;
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        node_q  <= '0;
        level_q <= '0;
      end
      S_NODE: begin
        if (nd.leaf) begin
          res_pred_q <= nd.value;
          res_stat_q <= 1'b0;
        end else begin
          res_pred_q <= '0;
          res_stat_q <= 1'b1;
        end
      end
      S_FEAT: begin
        node_q     <= child;
        level_q    <= level_q + LIMIT_W'(1);
        res_pred_q <= '0;
        res_stat_q <= 1'b1;
      end
      S_DONE: begin
        if (out_free) begin
          out_pred_q <= res_pred_q;
          out_stat_q <= res_stat_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign prediction_o = out_pred_q;
  assign status_o     = out_stat_q;

endmodule

`default_nettype wire

[design/dtinf_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module dtinf_checker (
  input wire logic                                 clk_i,
  input wire logic                                 rst_ni,
  input wire logic                                 in_valid_i,
  input wire logic                                 in_stall_o,
  input wire logic [1:0]                           op_i,
  input wire logic                                 out_valid_o,
  input wire logic                                 out_stall_i,
  input wire logic signed [dtinf_pkg::VALUE_W-1:0] prediction_o,
  input wire logic                                 status_o
);

  import dtinf_pkg::*;

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(prediction_o) && $stable(status_o))
    else $error("stalled result word changed");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> prediction_o == '0)
    else $error("error result with nonzero prediction");

  a_walk_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && op_i == OP_PREDICT |=> in_stall_o)
    else $error("input not stalled during walk");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && op_i != OP_PREDICT |=> !in_stall_o)
    else $error("input stalled after table or row word");

endmodule

bind decision_tree_inference_unit dtinf_checker u_dtinf_checker (.*);

`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;

  import dtinf_pkg::*;

  localparam int unsigned NODES        = 511;
  localparam int unsigned FEATURES     = 16;
  localparam int unsigned MAX_LEVELS   = 8;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned MIX_ITEMS    = 140;
  localparam int unsigned TAIL_ITEMS   = 150;

  typedef struct packed {
    logic signed [VALUE_W-1:0] prediction;
    logic                      status;
  } verdict_t;

  logic                         clk_i;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we_i = 1'b0;
  logic [LIMIT_W-1:0]           cfg_wdata_i = '0;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  logic [1:0]                   op_i = '0;
  logic [NODE_IDX_W-1:0]        node_index_i = '0;
  logic                         node_is_leaf_i = 1'b0;
  logic [FEAT_IDX_W-1:0]        node_feature_i = '0;
  logic signed [VALUE_W-1:0]    node_value_i = '0;
  logic [FEAT_IDX_W-1:0]        feature_index_i = '0;
  logic signed [VALUE_W-1:0]    feature_value_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic signed [VALUE_W-1:0]    prediction_o;
  logic                         status_o;

  node_t                     tree_mem [NODES];
  bit                        node_set [NODES];
  logic signed [VALUE_W-1:0] row_mem  [FEATURES];
  bit                        row_set  [FEATURES];
  logic [LIMIT_W-1:0]        depth_limit_q = LIMIT_RESET;
  verdict_t                  verdict_q [$];
  int                        err_count = 0;
  bit                        src_idle_en = 1'b0;
  bit                        sink_idle_en = 1'b0;
  bit                        hold_req = 1'b0;

  decision_tree_inference_unit #(
    .NODES     (NODES),
    .FEATURES  (FEATURES),
    .MAX_LEVELS(MAX_LEVELS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .node_index_i   (node_index_i),
    .node_is_leaf_i (node_is_leaf_i),
    .node_feature_i (node_feature_i),
    .node_value_i   (node_value_i),
    .feature_index_i(feature_index_i),
    .feature_value_i(feature_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .prediction_o   (prediction_o),
    .status_o       (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  // walk the tree; report the first unwritten node or row entry instead of reading it
  function automatic void walk_tree(output verdict_t v, output int gap_node,
                                    output int gap_feat);
    int unsigned node;
    int unsigned level;
    int unsigned lim;
    node_t       cur;
    v.prediction = '0;
    v.status     = 1'b1;
    gap_node     = -1;
    gap_feat     = -1;
    lim   = (depth_limit_q > MAX_LEVELS) ? MAX_LEVELS : depth_limit_q;
    node  = 0;
    level = 0;
    while (node < NODES) begin
      if (!node_set[node]) begin
        gap_node = node;
        break;
      end
      cur = tree_mem[node];
      if (cur.leaf) begin
        v.prediction = cur.value;
        v.status     = 1'b0;
        break;
      end
      if (level >= lim || cur.feat >= FEATURES) break;
      if (!row_set[cur.feat]) begin
        gap_feat = cur.feat;
        break;
      end
      if ($signed(row_mem[cur.feat]) < $signed(cur.value)) node = 2 * node + 1;
      else node = 2 * node + 2;
      level++;
    end
  endfunction

  function automatic logic [VALUE_W-1:0] rand_q16();
    case ($urandom_range(0, 7))
      0: rand_q16 = 32'h8000_0000;
      1: rand_q16 = 32'h7fff_ffff;
      2: rand_q16 = '0;
      3: rand_q16 = ($urandom_range(0, 8) - 4) <<< 16;
      default: rand_q16 = $urandom;
    endcase
  endfunction

  task automatic send_word(input logic [1:0] op, input logic [NODE_IDX_W-1:0] nidx,
                           input logic leaf, input logic [FEAT_IDX_W-1:0] nfeat,
                           input logic [VALUE_W-1:0] nval,
                           input logic [FEAT_IDX_W-1:0] fidx,
                           input logic [VALUE_W-1:0] fval);
    verdict_t v;
    int       gn;
    int       gf;
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    op_i            <= op;
    node_index_i    <= nidx;
    node_is_leaf_i  <= leaf;
    node_feature_i  <= nfeat;
    node_value_i    <= nval;
    feature_index_i <= fidx;
    feature_value_i <= fval;
    do @(posedge clk_i); while (in_stall_o);
    case (op)
      OP_WRITE_NODE: if (nidx < NODES) begin
        tree_mem[nidx] = '{leaf: leaf, feat: nfeat, value: nval};
        node_set[nidx] = 1'b1;
      end
      OP_LOAD_FEAT: if (fidx < FEATURES) begin
        row_mem[fidx] = fval;
        row_set[fidx] = 1'b1;
      end
      OP_PREDICT: begin
        walk_tree(v, gn, gf);
        verdict_q = {verdict_q, v};
      end
      default: ;
    endcase
  endtask

  task automatic send_blank(input logic [1:0] op);
    send_word(op, NODE_IDX_W'($urandom), 1'($urandom), FEAT_IDX_W'($urandom),
              VALUE_W'($urandom), FEAT_IDX_W'($urandom), VALUE_W'($urandom));
  endtask

  task automatic write_node(input logic [NODE_IDX_W-1:0] nidx, input logic leaf,
                            input logic [FEAT_IDX_W-1:0] nfeat,
                            input logic [VALUE_W-1:0] nval);
    send_word(OP_WRITE_NODE, nidx, leaf, nfeat, nval, FEAT_IDX_W'($urandom),
              VALUE_W'($urandom));
  endtask

  task automatic load_feature(input logic [FEAT_IDX_W-1:0] fidx,
                              input logic [VALUE_W-1:0] fval);
    send_word(OP_LOAD_FEAT, NODE_IDX_W'($urandom), 1'($urandom), FEAT_IDX_W'($urandom),
              VALUE_W'($urandom), fidx, fval);
  endtask

  // fill whatever the walk would read unwritten, then predict
  task automatic predict_row();
    verdict_t v;
    int       gn;
    int       gf;
    forever begin
      walk_tree(v, gn, gf);
      if (gn >= 0)
        write_node(NODE_IDX_W'(gn), 1'($urandom_range(0, 1)), FEAT_IDX_W'($urandom),
                   rand_q16());
      else if (gf >= 0) load_feature(FEAT_IDX_W'(gf), rand_q16());
      else break;
    end
    send_blank(OP_PREDICT);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_depth_limit(input logic [LIMIT_W-1:0] lim);
    wait_idle();
    cfg_wdata_i <= lim;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    depth_limit_q = lim;
  endtask

  task automatic test_split_direction();
    write_node(9'd0, 1'b0, 4'd0, 32'h0000_0000);
    write_node(9'd1, 1'b1, 4'd7, 32'h7fff_ffff);
    write_node(9'd2, 1'b1, 4'd9, 32'h8000_0000);
    load_feature(4'd0, 32'hffff_ffff);
    predict_row();
    load_feature(4'd0, 32'h0000_0000);
    predict_row();
  endtask

  task automatic test_depth_chain();
    for (int lvl = 0; lvl <= MAX_LEVELS; lvl++)
      write_node(NODE_IDX_W'((1 << lvl) - 1), 1'b0, 4'd15, 32'h7fff_ffff);
    load_feature(4'd15, 32'h8000_0000);
    predict_row();
    write_node(9'd255, 1'b1, 4'd0, 32'hffff_ffff);
    predict_row();
  endtask

  task automatic test_limit_extremes();
    set_depth_limit(4'd0);
    predict_row();
    set_depth_limit(4'd15);
    predict_row();
  endtask

  task automatic test_ignored_words();
    write_node(9'd511, 1'b1, 4'd15, 32'h1234_5678);
    send_blank(OP_UNUSED);
    predict_row();
  endtask

  task automatic test_backpressure();
    bit idle_save;
    idle_save   = src_idle_en;
    src_idle_en = 1'b0;
    hold_req    = 1'b1;
    repeat (16) predict_row();
    src_idle_en = idle_save;
  endtask

  task automatic test_random_mix(input int unsigned count);
    int unsigned pick;
    int unsigned lim;
    repeat (count) begin
      lim  = (depth_limit_q > MAX_LEVELS) ? MAX_LEVELS : depth_limit_q;
      pick = $urandom_range(0, 99);
      if (pick < 35) load_feature(FEAT_IDX_W'($urandom), rand_q16());
      else if (pick < 65) predict_row();
      else if (pick < 90)
        write_node(NODE_IDX_W'($urandom_range(0, (2 << lim) - 2)),
                   1'($urandom_range(0, 1)), FEAT_IDX_W'($urandom), rand_q16());
      else if (pick < 96)
        write_node(NODE_IDX_W'($urandom_range(0, 511)), 1'($urandom_range(0, 1)),
                   FEAT_IDX_W'($urandom), rand_q16());
      else
        send_blank(OP_UNUSED);
    end
  endtask

  initial begin : sink_stall
    int n;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 9);
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    verdict_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h status %0b",
                 $time, prediction_o, status_o);
        err_count++;
      end else begin
        want = verdict_q.pop_front();
        if (prediction_o !== want.prediction) begin
          $display("%0t: prediction mismatch, expected %h, actual %h",
                   $time, want.prediction, prediction_o);
          err_count++;
        end
        if (status_o !== want.status) begin
          $display("%0t: status mismatch, expected %0b, actual %0b",
                   $time, want.status, status_o);
          err_count++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [LIMIT_W-1:0] limits [8];
    limits = '{4'd0, 4'd15, 4'd3, 4'd1, 4'd6, 4'd9, 4'd2, 4'd8};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    test_split_direction();
    test_depth_chain();
    test_limit_extremes();
    test_ignored_words();
    test_backpressure();
    foreach (limits[i]) begin
      set_depth_limit(limits[i]);
      test_random_mix(MIX_ITEMS);
    end
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    test_random_mix(TAIL_ITEMS);
    wait_idle();
    if (err_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

[sim.f]
design/dtinf_pkg.sv
design/dtinf_ram.sv
design/decision_tree_inference_unit.sv
design/dtinf_checker.sv
verif/tb.sv
